>>> rtl/core/bsc_pkg.sv
package bsc_pkg;

    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 64;

    localparam logic [CfgIdxW-1:0] CFG_TEMP = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_PLO = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_PHI = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_P9H = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_HREST = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_HPRES = 3'd5;

    typedef struct packed {
        logic [19:0] raw_pressure;
        logic [19:0] raw_temperature;
        logic [15:0] raw_humidity;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic [31:0] pressure_fixed;
        logic pressure_valid;
        logic [16:0] humidity_fixed;
    } out_item_t;

    // calibration words held by the top level
    typedef struct packed {
        logic [47:0] cal_t;
        logic [63:0] cal_plo;
        logic [63:0] cal_phi;
        logic [47:0] cal_p9h;
        logic [39:0] cal_hrest;
        logic hum_on;
    } cal_t;

    // classified transaction handed from front to back
    typedef struct packed {
        logic [31:0] fine;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } job_t;

endpackage

>>> rtl/core/bsc_front.sv
module bsc_front
    import bsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     go,
    input  in_item_t item,
    input  cal_t     cal,
    output logic     job_valid,
    output job_t     job
);

    // stage 1 registers
    logic        s1_valid_reg;
    logic [31:0] v1_reg, b_reg;
    logic [19:0] p_s1_reg;
    logic [15:0] h_s1_reg;

    logic [31:0] t1, t2, t3, a, b, prod_a;

    assign t1 = {16'd0, cal.cal_t[15:0]};
    assign t2 = {{16{cal.cal_t[31]}}, cal.cal_t[31:16]};
    assign t3 = {{16{cal.cal_t[47]}}, cal.cal_t[47:32]};
    assign a = {15'd0, item.raw_temperature[19:3]} - (t1 << 1);
    assign b = {16'd0, item.raw_temperature[19:4]} - t1;
    assign prod_a = a * t2;

    // temperature pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= go;
        end
    end

    always_ff @(posedge clk)
    begin
        v1_reg <= $signed(prod_a) >>> 11;
        b_reg <= b;
        p_s1_reg <= item.raw_pressure;
        h_s1_reg <= item.raw_humidity;
    end

    // square is a second multiply, kept in its own stage
    logic [31:0] b_sq;
    logic [31:0] v2c;
    assign b_sq = b_reg * b_reg;
    assign v2c = ($signed(b_sq) >>> 12);

    logic [31:0] v2x_reg, v1x_reg;
    logic        s3_valid_reg;
    logic [19:0] p_s3_reg;
    logic [15:0] h_s3_reg;
    logic [31:0] m3;
    assign m3 = v2x_reg * t3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        v2x_reg <= v2c;
        v1x_reg <= v1_reg;
        p_s3_reg <= p_s1_reg;
        h_s3_reg <= h_s1_reg;
    end

    logic [31:0] v2f;
    assign v2f = $signed(m3) >>> 14;

    assign job_valid = s3_valid_reg;
    assign job.fine = v1x_reg + v2f;
    assign job.raw_pressure = p_s3_reg;
    assign job.raw_humidity = h_s3_reg;

endmodule

>>> rtl/core/bsc_fifo.sv
module bsc_fifo
    import bsc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t wdata,
    input  logic pop,
    output logic nonempty,
    output job_t rdata
);

    localparam int Depth = 4;

    job_t       mem_reg [Depth];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign nonempty = cnt_reg != 3'd0;
    assign rdata = mem_reg[rp_reg];

    // pointer and count upkeep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 2'd0;
            rp_reg <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 2'd1;
            if (pop)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, push} - {2'd0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wdata;
    end

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> nonempty)
        else $error("fifo pop while empty");
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 3'd4)
        else $error("fifo count beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 3'd4) |-> !push || pop)
        else $error("fifo overflow");

endmodule

>>> rtl/core/bsc_back.sv
module bsc_back
    import bsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    input  job_t      job,
    input  cal_t      cal,
    output logic      job_take,
    output logic      done,
    output out_item_t result
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_X1   = 10'b0000000010,
        S_X2   = 10'b0000000100,
        S_X3   = 10'b0000001000,
        S_X4   = 10'b0000010000,
        S_DIV  = 10'b0000100000,
        S_P1   = 10'b0001000000,
        S_P2   = 10'b0010000000,
        S_P3   = 10'b0100000000,
        S_DONE = 10'b1000000000
    } st_t;

    st_t st_reg;
    logic [5:0] cnt_reg;
    logic [3:0] step_reg;
    logic [63:0] x1_reg, x2_reg, acc_reg, tmp_reg, num_reg, den_reg, rem_reg;
    logic [63:0] p_reg;
    logic        neg_reg, pv_reg;
    logic [31:0] fine_reg;
    logic [19:0] rp_reg;
    logic [15:0] rh_reg;
    logic [31:0] hv_reg, ha_reg, hb_reg, hw_reg;

    // shared multiplier: 64x64 low product computed as 32x32 partials over cycles
    logic [63:0] ma_reg, mb_reg, mprod_reg;
    logic [1:0]  mph_reg;
    logic [63:0] mpart;
    logic [31:0] mop_a, mop_b;
    always_comb
    begin
        case (mph_reg)
            2'd0:    begin mop_a = ma_reg[31:0];  mop_b = mb_reg[31:0];  end
            2'd1:    begin mop_a = ma_reg[63:32]; mop_b = mb_reg[31:0];  end
            default: begin mop_a = ma_reg[31:0];  mop_b = mb_reg[63:32]; end
        endcase
    end
    assign mpart = {32'd0, mop_a} * {32'd0, mop_b};

    function automatic logic [63:0] sx16(input logic [15:0] v);
        sx16 = {{48{v[15]}}, v};
    endfunction

    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign p1 = {48'd0, cal.cal_plo[15:0]};
    assign p2 = sx16(cal.cal_plo[31:16]);
    assign p3 = sx16(cal.cal_plo[47:32]);
    assign p4 = sx16(cal.cal_plo[63:48]);
    assign p5 = sx16(cal.cal_phi[15:0]);
    assign p6 = sx16(cal.cal_phi[31:16]);
    assign p7 = sx16(cal.cal_phi[47:32]);
    assign p8 = sx16(cal.cal_phi[63:48]);
    assign p9 = sx16(cal.cal_p9h[15:0]);

    logic [31:0] h1, h2, h3, h4, h5, h6;
    assign h1 = {24'd0, cal.cal_p9h[23:16]};
    assign h2 = {{16{cal.cal_p9h[39]}}, cal.cal_p9h[39:24]};
    assign h3 = {24'd0, cal.cal_p9h[47:40]};
    assign h4 = {{16{cal.cal_hrest[15]}}, cal.cal_hrest[15:0]};
    assign h5 = {{16{cal.cal_hrest[31]}}, cal.cal_hrest[31:16]};
    assign h6 = {{24{cal.cal_hrest[39]}}, cal.cal_hrest[39:32]};

    // micro-op list: product mprod = ma*mb summed from three 32x32 partials
    // step numbering inside S_X*/S_P* selects operands
    logic        mbusy_reg;
    logic        mstart;
    logic [63:0] mstart_a, mstart_b;
    logic        mdone;
    assign mdone = mbusy_reg && (mph_reg == 2'd2);

    // restoring divider on magnitudes
    logic [64:0] dsub;
    logic [63:0] rem_sh;
    assign rem_sh = {rem_reg[62:0], num_reg[63]};
    assign dsub = {1'b0, rem_sh} - {1'b0, den_reg};

    assign job_take = (st_reg == S_IDLE) && job_valid;

    logic [31:0] temp_w;
    logic [31:0] tf5;
    assign tf5 = fine_reg * 32'd5 + 32'd128;
    assign temp_w = $signed(tf5) >>> 8;

    always_comb
    begin
        mstart = 1'b0;
        mstart_a = 64'd0;
        mstart_b = 64'd0;
        unique case (st_reg)
            S_X1:
            begin
                mstart = !mbusy_reg;
                unique case (step_reg)
                    4'd0:    begin mstart_a = x1_reg;  mstart_b = x1_reg; end
                    4'd1:    begin mstart_a = tmp_reg; mstart_b = p6;     end
                    4'd2:    begin mstart_a = x1_reg;  mstart_b = p5;     end
                    4'd3:    begin mstart_a = tmp_reg; mstart_b = p3;     end
                    4'd4:    begin mstart_a = x1_reg;  mstart_b = p2;     end
                    default: begin mstart_a = acc_reg; mstart_b = p1;     end
                endcase
            end
            S_P1:
            begin
                mstart = !mbusy_reg;
                unique case (step_reg)
                    4'd0:    begin mstart_a = num_reg; mstart_b = 64'd3125; end
                    4'd1:    begin mstart_a = p9;      mstart_b = tmp_reg;  end
                    4'd2:    begin mstart_a = acc_reg; mstart_b = tmp_reg;  end
                    default: begin mstart_a = p8;      mstart_b = p_reg;    end
                endcase
            end
            S_P3:
            begin
                // no product is started without the humidity channel
                mstart = !mbusy_reg && cal.hum_on;
                unique case (step_reg)
                    4'd0:    begin mstart_a = {32'd0, h5};     mstart_b = {32'd0, hv_reg}; end
                    4'd1:    begin mstart_a = {32'd0, hv_reg}; mstart_b = {32'd0, h6};     end
                    4'd2:    begin mstart_a = {32'd0, hv_reg}; mstart_b = {32'd0, h3};     end
                    4'd3:    begin mstart_a = {32'd0, hw_reg}; mstart_b = {32'd0, hb_reg}; end
                    4'd4:    begin mstart_a = {32'd0, hb_reg}; mstart_b = {32'd0, h2};     end
                    4'd5:    begin mstart_a = {32'd0, ha_reg}; mstart_b = {32'd0, hb_reg}; end
                    4'd6:    begin mstart_a = {32'd0, hw_reg}; mstart_b = {32'd0, hw_reg}; end
                    default: begin mstart_a = {32'd0, hw_reg}; mstart_b = {32'd0, h1};     end
                endcase
            end
            default: mstart = 1'b0;
        endcase
    end

    // multiplier sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg <= 1'b0;
            mph_reg <= 2'd0;
        end
        else if (mstart)
        begin
            mbusy_reg <= 1'b1;
            mph_reg <= 2'd0;
        end
        else if (mbusy_reg)
        begin
            mph_reg <= mph_reg + 2'd1;
            if (mph_reg == 2'd2)
                mbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mstart)
        begin
            ma_reg <= mstart_a;
            mb_reg <= mstart_b;
        end
        if (mbusy_reg)
        begin
            unique case (mph_reg)
                2'd0:    mprod_reg <= mpart;
                2'd1:    mprod_reg <= mprod_reg + {mpart[31:0], 32'd0};
                default: mprod_reg <= mprod_reg + {mpart[31:0], 32'd0};
            endcase
        end
    end

    logic [63:0] prod;
    assign prod = mprod_reg + {mpart[31:0], 32'd0};

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            step_reg <= 4'd0;
            cnt_reg <= 6'd0;
            done <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                    if (job_valid)
                    begin
                        st_reg <= S_X1;
                        step_reg <= 4'd0;
                    end
                S_X1:
                    if (mdone)
                    begin
                        if (step_reg == 4'd5)
                            st_reg <= S_X2;
                        else
                            step_reg <= step_reg + 4'd1;
                    end
                S_X2: st_reg <= (x1_reg == 64'd0) ? S_X4 : S_X3;
                S_X3:
                begin
                    st_reg <= S_P1;
                    step_reg <= 4'd0;
                end
                S_X4:
                begin
                    st_reg <= S_P3;
                    step_reg <= 4'd0;
                end
                S_P1:
                    if (mdone)
                    begin
                        if (step_reg == 4'd0)
                        begin
                            st_reg <= S_DIV;
                            cnt_reg <= 6'd0;
                        end
                        else if (step_reg == 4'd3)
                        begin
                            st_reg <= S_P2;
                        end
                        else
                            step_reg <= step_reg + 4'd1;
                    end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                    begin
                        st_reg <= S_P1;
                        step_reg <= 4'd1;
                    end
                end
                S_P2:
                begin
                    st_reg <= S_P3;
                    step_reg <= 4'd0;
                end
                S_P3:
                    if (!cal.hum_on)
                        st_reg <= S_DONE;
                    else if (mdone)
                    begin
                        if (step_reg == 4'd7)
                            st_reg <= S_DONE;
                        else
                            step_reg <= step_reg + 4'd1;
                    end
                S_DONE:
                begin
                    st_reg <= S_IDLE;
                    done <= 1'b1;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    logic [31:0] p32;
    assign p32 = prod[31:0];

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            S_IDLE:
                if (job_valid)
                begin
                    fine_reg <= job.fine;
                    rp_reg <= job.raw_pressure;
                    rh_reg <= job.raw_humidity;
                    x1_reg <= {{32{job.fine[31]}}, job.fine} - 64'd128000;
                    hv_reg <= job.fine - 32'd76800;
                    pv_reg <= 1'b0;
                    p_reg <= 64'd0;
                    hw_reg <= 32'd0;
                end
            S_X1:
                if (mdone)
                    unique case (step_reg)
                        4'd0: tmp_reg <= prod;
                        4'd1: x2_reg <= prod;
                        4'd2: x2_reg <= x2_reg + (prod << 17) + (p4 << 35);
                        4'd3: acc_reg <= $signed(prod) >>> 8;
                        4'd4: acc_reg <= acc_reg + (prod << 12) + (64'd1 << 47);
                        default: x1_reg <= $signed(prod) >>> 33;
                    endcase
            S_X3:
                num_reg <= ({43'd0, 21'd1048576 - {1'b0, rp_reg}} << 31) - x2_reg;
            S_P1:
                if (mdone)
                    unique case (step_reg)
                        4'd0:
                        begin
                            neg_reg <= prod[63] ^ x1_reg[63];
                            num_reg <= prod[63] ? 64'd0 - prod : prod;
                            den_reg <= x1_reg[63] ? 64'd0 - x1_reg : x1_reg;
                            rem_reg <= 64'd0;
                        end
                        4'd1: acc_reg <= prod;
                        4'd2: x2_reg <= $signed(prod) >>> 25;
                        default: x1_reg <= $signed(prod) >>> 19;
                    endcase
            S_DIV:
            begin
                num_reg <= {num_reg[62:0], !dsub[64]};
                rem_reg <= dsub[64] ? rem_sh : dsub[63:0];
                if (cnt_reg == 6'd63)
                begin
                    p_reg <= neg_reg ? 64'd0 - {num_reg[62:0], !dsub[64]}
                                     : {num_reg[62:0], !dsub[64]};
                    tmp_reg <= $signed(neg_reg ? 64'd0 - {num_reg[62:0], !dsub[64]}
                                     : {num_reg[62:0], !dsub[64]}) >>> 13;
                end
            end
            S_P2:
            begin
                p_reg <= $unsigned($signed(p_reg + x2_reg + x1_reg) >>> 8) + (p7 << 4);
                pv_reg <= 1'b1;
            end
            S_P3:
                if (mdone)
                    unique case (step_reg)
                        4'd0:
                            ha_reg <= $signed(({rh_reg, 14'd0} - (h4 << 20) - p32
                                     + 32'd16384)) >>> 15;
                        4'd1: hw_reg <= $signed(p32) >>> 10;
                        4'd2: hb_reg <= $unsigned($signed(p32) >>> 11) + 32'd32768;
                        4'd3: hb_reg <= $unsigned($signed(p32) >>> 10) + 32'd2097152;
                        4'd4: hb_reg <= $signed(p32 + 32'd8192) >>> 14;
                        4'd5: hw_reg <= p32;
                        4'd6:
                        begin
                            hb_reg <= hw_reg;
                            hw_reg <= $signed(($signed(hw_reg) >>> 15) * ($signed(hw_reg) >>> 15)) >>> 7;
                        end
                        default: hw_reg <= hb_reg - $unsigned($signed(p32) >>> 4);
                    endcase
            default: ;
        endcase
    end

    // output formatting
    always_ff @(posedge clk)
    begin
        if (st_reg == S_DONE)
        begin
            result.temperature_centi <= temp_w;
            result.pressure_valid <= pv_reg;
            if (!pv_reg || p_reg[63])
                result.pressure_fixed <= 32'd0;
            else if (p_reg[62:32] != 31'd0)
                result.pressure_fixed <= 32'hFFFF_FFFF;
            else
                result.pressure_fixed <= p_reg[31:0];
            if (!cal.hum_on || hw_reg[31])
                result.humidity_fixed <= 17'd0;
            else if (hw_reg > 32'd419430400)
                result.humidity_fixed <= 17'd102400;
            else
                result.humidity_fixed <= hw_reg[28:12];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(st_reg) == S_DONE)
        else $error("result without completion");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_DIV) |=> (st_reg == S_DIV) || (st_reg == S_P1))
        else $error("divider left early");
    assert property (@(posedge clk) disable iff (!rst_n) job_take |=> st_reg == S_X1)
        else $error("job taken without start");

endmodule

>>> rtl/core/barometric_sensor_compensation.sv
// Barometric sensor compensation.
// Command channel: drive in_item with start high; an item is taken at a
// rising edge with start high and busy low. busy rises only when four
// transactions sit in the front pipe and job queue, so items may arrive
// on back-to-back cycles in short bursts.
// The front stage forms the fine temperature term and pushes a job into
// a four-entry queue once it has passed the stage 1 and stage 3
// registers. The back sequencer runs the pressure and humidity formulas
// on one shared 32x32 multiplier (each 64-bit product is summed from three
// partials after the operand load) and a one-bit-per-cycle 64-step divider.
// A zero pressure divisor skips the divider and the pressure steps; the
// humidity steps run only with the humidity channel on. The back takes
// a new job only once it is idle again after the previous result.
// Each result is shown on out_item for one cycle with done high; the
// receiver cannot stall it. Calibration is written through cfg_we /
// cfg_index / cfg_data; the user must do so only while idle, which the
// block itself does not enforce. Reset clears calibration to zero,
// empties the queue and idles the back.
module barometric_sensor_compensation
    import bsc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  in_item_t            in_item,
    output logic                done,
    output out_item_t           out_item,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    cal_t cal_reg;
    logic go, jv, jt, qne;
    job_t fj, qj;
    logic [2:0] infl_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cal_reg <= '0;
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TEMP:  cal_reg.cal_t <= cfg_data[47:0];
                CFG_PLO:   cal_reg.cal_plo <= cfg_data;
                CFG_PHI:   cal_reg.cal_phi <= cfg_data;
                CFG_P9H:   cal_reg.cal_p9h <= cfg_data[47:0];
                CFG_HREST: cal_reg.cal_hrest <= cfg_data[39:0];
                CFG_HPRES: cal_reg.hum_on <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // count of jobs in the front pipe plus queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            infl_reg <= 3'd0;
        else
            infl_reg <= infl_reg + {2'd0, go} - {2'd0, jt};
    end

    assign busy = infl_reg >= 3'd4;
    assign go = start && !busy;

    bsc_front u_front (
        .clk(clk), .rst_n(rst_n), .go(go), .item(in_item), .cal(cal_reg),
        .job_valid(jv), .job(fj)
    );

    bsc_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .push(jv), .wdata(fj), .pop(jt),
        .nonempty(qne), .rdata(qj)
    );

    bsc_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(qne), .job(qj), .cal(cal_reg),
        .job_take(jt), .done(done), .result(out_item)
    );

endmodule
